>>> hw/rtl/williams_percent_r_window_defines.svh
// assertion macros used by williams_percent_r_window.sv
`ifndef WILLIAMS_PERCENT_R_WINDOW_DEFINES_SVH
`define WILLIAMS_PERCENT_R_WINDOW_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wpr_pkg.sv
package wpr_pkg;

    // default sizing
    localparam int MAX_WINDOW_DEF = 128;
    localparam int PRICE_BITS_DEF = 32;

    // fixed field widths
    localparam int FIELD_BITS = 32;
    localparam int CFG_BITS   = 8;
    localparam int PCT_BITS   = 23;

    // 100 percent in q16, and the window length after reset
    localparam logic [PCT_BITS-1:0] FULL_SCALE   = 23'd6553600;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 8'd10;

    // one price bar
    typedef struct packed {
        logic [FIELD_BITS-1:0] high_price;
        logic [FIELD_BITS-1:0] low_price;
        logic [FIELD_BITS-1:0] close_price;
        logic                  series_start;
    } bar_t;

    // one result
    typedef struct packed {
        logic [PCT_BITS-1:0] percent_r_q16;
        logic                result_valid;
    } wpr_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } wpr_state_t;

endpackage

>>> hw/rtl/williams_percent_r_window.sv
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+-------------------------------
// bar       | in        | bar_valid / bar_stall    | bar_data   (wpr_pkg::bar_t)
// wpr       | out       | wpr_valid / wpr_stall    | wpr_data   (wpr_pkg::wpr_t)
// cfg       | in        | cfg_write_en             | cfg_write_data (window length)
//
// an item runs through scan and check, then scale and the divider unless the result is
// flat or clamped, and then finishes in done
// the scan reads one ring entry a cycle through the single read port of the ring
// memory; the divider then produces one quotient bit a cycle
// bar_stall is high from acceptance until the result moves to the output register
// a result waiting on wpr_stall does not block the next item; the ring memory has
// no reset and the window restarts empty after rst_n
`include "williams_percent_r_window_defines.svh"

module williams_percent_r_window #(
    parameter int MAX_WINDOW = wpr_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = wpr_pkg::PRICE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [wpr_pkg::CFG_BITS-1:0]  cfg_write_data,
    input  logic                          bar_valid,
    output logic                          bar_stall,
    input  wpr_pkg::bar_t                 bar_data,
    output logic                          wpr_valid,
    input  logic                          wpr_stall,
    output wpr_pkg::wpr_t                 wpr_data
);

    localparam int PW     = PRICE_BITS;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W  = (wpr_pkg::CFG_BITS > CNT_W) ? wpr_pkg::CFG_BITS : CNT_W;
    localparam int QB     = wpr_pkg::PCT_BITS;
    localparam int DCNT_W = $clog2(QB);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_WINDOW);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_WINDOW);

    // control registers
    wpr_pkg::wpr_state_t state_reg, state_next;
    logic [wpr_pkg::CFG_BITS-1:0] window_length_reg;
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]  rd_left_reg, rd_left_next;
    logic              rd_pending_reg, rd_pending_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic              wpr_valid_reg, wpr_valid_next;

    // payload registers
    logic [PW-1:0] highest_reg, highest_next;
    logic [PW-1:0] lowest_reg, lowest_next;
    logic [PW-1:0] close_reg, close_next;
    logic [PW-1:0] range_reg, range_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [QB-1:0] shreg_reg, shreg_next;
    logic [QB-1:0] quo_reg, quo_next;
    logic          res_ok_reg, res_ok_next;
    wpr_pkg::wpr_t wpr_data_reg, wpr_data_next;

    // ring memory, high in the upper half, low in the lower half
    logic [2*PW-1:0] ring_mem [MAX_WINDOW];
    logic [2*PW-1:0] ring_q_reg;
    logic            ring_we;
    logic [SLOT_W-1:0] ring_waddr;
    logic [2*PW-1:0] ring_wdata;

    // combinational helpers
    logic              accept;
    logic [PW-1:0]     bar_high, bar_low, bar_close;
    logic [SLOT_W-1:0] base_slot;
    logic [CNT_W-1:0]  base_fill, fill_new, span;
    logic [LEN_W-1:0]  len_raw, len_sel;
    logic [CNT_W-1:0]  len_c;
    logic [PW-1:0]     q_high, q_low, diff;
    logic [PW+4:0]     scaled;
    logic [PW:0]       trial;
    logic              load_out;

    assign accept    = bar_valid && !bar_stall;
    assign bar_stall = (state_reg != wpr_pkg::ST_IDLE);
    assign wpr_valid = wpr_valid_reg;
    assign wpr_data  = wpr_data_reg;

    assign bar_high  = PW'(bar_data.high_price);
    assign bar_low   = PW'(bar_data.low_price);
    assign bar_close = PW'(bar_data.close_price);
    assign q_high    = ring_q_reg[2*PW-1:PW];
    assign q_low     = ring_q_reg[PW-1:0];

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= wpr_pkg::WINDOW_RESET;
        end
        else if (cfg_write_en)
        begin
            window_length_reg <= cfg_write_data;
        end
    end

    // ring memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_q_reg <= ring_mem[rd_addr_reg];
    end

    // window length clamp and span for the incoming bar
    always_comb
    begin
        base_slot = bar_data.series_start ? '0 : write_slot_reg;
        base_fill = bar_data.series_start ? '0 : fill_count_reg;
        fill_new  = (base_fill == CNT_MAX) ? base_fill : base_fill + CNT_W'(1);
        len_raw   = LEN_W'(window_length_reg);
        if (len_raw == '0)
        begin
            len_sel = LEN_W'(1);
        end
        else if (len_raw > LEN_MAX)
        begin
            len_sel = LEN_MAX;
        end
        else
        begin
            len_sel = len_raw;
        end
        len_c = CNT_W'(len_sel);
        span  = (len_c < fill_new) ? len_c : fill_new;
    end

    // datapath helpers: scaling by 100 * 65536 = 25 << 18, and one divide step
    always_comb
    begin
        diff   = highest_reg - close_reg;
        scaled = ((PW+5)'(diff) << 4) + ((PW+5)'(diff) << 3) + (PW+5)'(diff);
        trial  = {rem_reg, shreg_reg[QB-1]};
    end

    // sequencer: next state and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        write_slot_next = write_slot_reg;
        rd_addr_next    = rd_addr_reg;
        rd_left_next    = rd_left_reg;
        rd_pending_next = 1'b0;
        div_cnt_next    = div_cnt_reg;
        wpr_valid_next  = wpr_valid_reg && wpr_stall;
        highest_next    = highest_reg;
        lowest_next     = lowest_reg;
        close_next      = close_reg;
        range_next      = range_reg;
        rem_next        = rem_reg;
        shreg_next      = shreg_reg;
        quo_next        = quo_reg;
        res_ok_next     = res_ok_reg;
        wpr_data_next   = wpr_data_reg;
        ring_we         = 1'b0;
        ring_waddr      = base_slot;
        ring_wdata      = {bar_high, bar_low};
        load_out        = 1'b0;

        unique case (state_reg)
            wpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ring_we         = 1'b1;
                    write_slot_next = (base_slot == SLOT_LAST) ? '0 : base_slot + SLOT_W'(1);
                    fill_count_next = fill_new;
                    rd_addr_next    = (base_slot == '0) ? SLOT_LAST : base_slot - SLOT_W'(1);
                    rd_left_next    = span - CNT_W'(1);
                    highest_next    = bar_high;
                    lowest_next     = bar_low;
                    close_next      = bar_close;
                    state_next      = wpr_pkg::ST_SCAN;
                end
            end

            wpr_pkg::ST_SCAN:
            begin
                // issue one read a cycle
                if (rd_left_reg != '0)
                begin
                    rd_pending_next = 1'b1;
                    rd_left_next    = rd_left_reg - CNT_W'(1);
                    rd_addr_next    = (rd_addr_reg == '0) ? SLOT_LAST
                                                          : rd_addr_reg - SLOT_W'(1);
                end
                // fold in the entry read last cycle
                if (rd_pending_reg)
                begin
                    if (q_high > highest_reg)
                    begin
                        highest_next = q_high;
                    end
                    if (q_low < lowest_reg)
                    begin
                        lowest_next = q_low;
                    end
                end
                if (rd_left_reg == '0 && !rd_pending_reg)
                begin
                    state_next = wpr_pkg::ST_CHECK;
                end
            end

            wpr_pkg::ST_CHECK:
            begin
                range_next = highest_reg - lowest_reg;
                quo_next   = '0;
                if (highest_reg > lowest_reg)
                begin
                    res_ok_next = 1'b1;
                    priority if (close_reg >= highest_reg)
                    begin
                        state_next = wpr_pkg::ST_DONE;
                    end
                    else if (close_reg <= lowest_reg)
                    begin
                        quo_next   = wpr_pkg::FULL_SCALE;
                        state_next = wpr_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = wpr_pkg::ST_SCALE;
                    end
                end
                else
                begin
                    res_ok_next = 1'b0;
                    state_next  = wpr_pkg::ST_DONE;
                end
            end

            wpr_pkg::ST_SCALE:
            begin
                // dividend is scaled << 18; its part above the quotient bits is below range
                rem_next     = scaled[PW+4:5];
                shreg_next   = {scaled[4:0], {(QB-5){1'b0}}};
                div_cnt_next = DCNT_W'(QB - 1);
                state_next   = wpr_pkg::ST_DIV;
            end

            wpr_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                shreg_next = {shreg_reg[QB-2:0], 1'b0};
                if (trial >= {1'b0, range_reg})
                begin
                    rem_next = PW'(trial - {1'b0, range_reg});
                    quo_next = {quo_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = PW'(trial);
                    quo_next = {quo_reg[QB-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    state_next = wpr_pkg::ST_DONE;
                end
            end

            wpr_pkg::ST_DONE:
            begin
                if (!wpr_valid_reg || !wpr_stall)
                begin
                    load_out   = 1'b1;
                    state_next = wpr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wpr_pkg::ST_IDLE;
            end
        endcase

        // output register load
        if (load_out)
        begin
            wpr_valid_next              = 1'b1;
            wpr_data_next.percent_r_q16 = res_ok_reg ? quo_reg : '0;
            wpr_data_next.result_valid  = res_ok_reg;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            write_slot_reg <= '0;
            rd_addr_reg    <= '0;
            rd_left_reg    <= '0;
            rd_pending_reg <= 1'b0;
            div_cnt_reg    <= '0;
            wpr_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            write_slot_reg <= write_slot_next;
            rd_addr_reg    <= rd_addr_next;
            rd_left_reg    <= rd_left_next;
            rd_pending_reg <= rd_pending_next;
            div_cnt_reg    <= div_cnt_next;
            wpr_valid_reg  <= wpr_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        highest_reg  <= highest_next;
        lowest_reg   <= lowest_next;
        close_reg    <= close_next;
        range_reg    <= range_next;
        rem_reg      <= rem_next;
        shreg_reg    <= shreg_next;
        quo_reg      <= quo_next;
        res_ok_reg   <= res_ok_next;
        wpr_data_reg <= wpr_data_next;
    end

    // checks
    `WPR_ASSERT_NEXT(a_accept_starts_scan, accept, state_reg == wpr_pkg::ST_SCAN, "accepted item did not start the scan")
    `WPR_ASSERT_NOW(a_fill_bounded, 1'b1, fill_count_reg <= CNT_MAX, "fill count above window depth")
    `WPR_ASSERT_NOW(a_scan_reads_bounded, state_reg == wpr_pkg::ST_SCAN, rd_left_reg < CNT_MAX, "scan would read the slot just written")
    `WPR_ASSERT_NOW(a_result_in_range, wpr_valid_reg, wpr_data_reg.percent_r_q16 <= wpr_pkg::FULL_SCALE, "result above full scale")
    `WPR_ASSERT_NEXT(a_load_sets_valid, load_out, wpr_valid_reg && state_reg == wpr_pkg::ST_IDLE, "result load did not show on the output")

endmodule
